/* hdl/ptps_pkg.sv */
// Shared types, pattern codes and the segment ROM of the priority tone pattern sequencer.
// Used by ptps_seq, priority_tone_pattern_sequencer and the test files; depends on nothing else.
`timescale 1ns / 1ps

package ptps_pkg;

	// Kinds of input transaction.
	localparam logic KIND_PLAY = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	// Pattern codes, numbered in rising priority.
	localparam logic [2:0] PAT_NONE       = 3'd0;
	localparam logic [2:0] PAT_KEYPRESS   = 3'd1;
	localparam logic [2:0] PAT_STARTUP    = 3'd2;
	localparam logic [2:0] PAT_LOWBATT    = 3'd3;
	localparam logic [2:0] PAT_LINKLOST   = 3'd4;
	localparam logic [2:0] PAT_RADIOERROR = 3'd5;
	localparam logic [2:0] PATTERN_COUNT  = 3'd6;

	// Stream widths, padded to whole bytes.
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 32;

	typedef struct packed {
		logic        kind;
		logic [2:0]  pattern_code;
		logic [15:0] tick_ms;
	} ptps_item_t;

	typedef struct packed {
		logic        tone_on;
		logic [10:0] reload_value;
		logic [9:0]  compare_value;
		logic        counter_restart;
		logic [2:0]  active_pattern;
	} ptps_result_t;

	// One ROM segment; the timer values are precomputed from 1e6 / frequency.
	typedef struct packed {
		logic        tone;
		logic [10:0] reload;
		logic [9:0]  compare;
		logic [7:0]  dur_ms;
	} seg_t;

	localparam seg_t SEG_ZERO   = '{tone: 1'b0, reload: 11'd0,    compare: 10'd0,   dur_ms: 8'd0};
	localparam seg_t SEG_2600_35  = '{1'b1, 11'd383,  10'd192, 8'd35};
	localparam seg_t SEG_1800_70  = '{1'b1, 11'd554,  10'd277, 8'd70};
	localparam seg_t SEG_2600_90  = '{1'b1, 11'd383,  10'd192, 8'd90};
	localparam seg_t SEG_1500_120 = '{1'b1, 11'd665,  10'd333, 8'd120};
	localparam seg_t SEG_900_180  = '{1'b1, 11'd1110, 10'd555, 8'd180};
	localparam seg_t SEG_700_250  = '{1'b1, 11'd1427, 10'd714, 8'd250};
	localparam seg_t SIL_40  = '{1'b0, 11'd0, 10'd0, 8'd40};
	localparam seg_t SIL_100 = '{1'b0, 11'd0, 10'd0, 8'd100};
	localparam seg_t SIL_120 = '{1'b0, 11'd0, 10'd0, 8'd120};

	// Number of segments in each pattern.
	function automatic logic [2:0] seg_count(input logic [2:0] pat);
		logic [2:0] cnt;
		cnt = 3'd0;
		unique case (pat)
			PAT_KEYPRESS:   cnt = 3'd1;
			PAT_STARTUP:    cnt = 3'd3;
			PAT_LOWBATT:    cnt = 3'd3;
			PAT_LINKLOST:   cnt = 3'd3;
			PAT_RADIOERROR: cnt = 3'd5;
			default:        cnt = 3'd0;
		endcase
		return cnt;
	endfunction

	// Segment ROM; positions beyond a pattern read as an empty segment.
	function automatic seg_t seg_lookup(input logic [2:0] pat, input logic [3:0] idx);
		seg_t s;
		s = SEG_ZERO;
		unique case (pat)
			PAT_KEYPRESS: begin
				if (idx == 4'd0) s = SEG_2600_35;
			end
			PAT_STARTUP: begin
				unique case (idx)
					4'd0:    s = SEG_1800_70;
					4'd1:    s = SIL_40;
					4'd2:    s = SEG_2600_90;
					default: s = SEG_ZERO;
				endcase
			end
			PAT_LOWBATT: begin
				unique case (idx)
					4'd0:    s = SEG_1500_120;
					4'd1:    s = SIL_100;
					4'd2:    s = SEG_1500_120;
					default: s = SEG_ZERO;
				endcase
			end
			PAT_LINKLOST: begin
				unique case (idx)
					4'd0:    s = SEG_900_180;
					4'd1:    s = SIL_120;
					4'd2:    s = SEG_900_180;
					default: s = SEG_ZERO;
				endcase
			end
			PAT_RADIOERROR: begin
				unique case (idx)
					4'd0:    s = SEG_700_250;
					4'd1:    s = SIL_100;
					4'd2:    s = SEG_700_250;
					4'd3:    s = SIL_100;
					4'd4:    s = SEG_700_250;
					default: s = SEG_ZERO;
				endcase
			end
			default: s = SEG_ZERO;
		endcase
		return s;
	endfunction

endpackage

/* hdl/ptps_seq.sv */
// Playback state and single-pass step logic of the tone pattern sequencer.
// Depends on ptps_pkg for the item/result types and the segment ROM.
`timescale 1ns / 1ps

module ptps_seq
	import ptps_pkg::*;
#(
	parameter int MAX_SEGMENTS = 5,
	parameter int PW           = 3
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         adv,
	input  ptps_item_t   item,
	output ptps_result_t result
);

	logic [2:0]    cur_q, cur_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [7:0]    tl_q, tl_d;
	logic          run_q, run_d;
	logic [10:0]   rl_q, rl_d;
	logic [9:0]    cp_q, cp_d;
	logic          restart;
	logic          load;
	logic [PW:0]   next_pos;
	seg_t          seg;

	// Next state for one transaction: request, tick, then segment load.
	always_comb begin
		cur_d    = cur_q;
		pos_d    = pos_q;
		tl_d     = tl_q;
		run_d    = run_q;
		rl_d     = rl_q;
		cp_d     = cp_q;
		restart  = 1'b0;
		load     = 1'b0;
		next_pos = {1'b0, pos_q} + {{PW{1'b0}}, 1'b1};
		seg      = SEG_ZERO;

		if (item.kind == KIND_PLAY) begin
			if (item.pattern_code != PAT_NONE && item.pattern_code >= cur_q) begin
				if (item.pattern_code >= PATTERN_COUNT ||
				    seg_count(item.pattern_code) == 3'd0) begin
					cur_d = PAT_NONE;
					pos_d = '0;
					tl_d  = 8'd0;
					run_d = 1'b0;
				end else begin
					cur_d = item.pattern_code;
					pos_d = '0;
					load  = 1'b1;
				end
			end
		end else if (cur_q != PAT_NONE) begin
			if ({8'd0, tl_q} > item.tick_ms) begin
				tl_d = tl_q - item.tick_ms[7:0];
			end else if (5'(next_pos) >= 5'(seg_count(cur_q)) ||
			             5'(next_pos) >= 5'(MAX_SEGMENTS)) begin
				cur_d = PAT_NONE;
				pos_d = '0;
				tl_d  = 8'd0;
				run_d = 1'b0;
			end else begin
				pos_d = next_pos[PW-1:0];
				load  = 1'b1;
			end
		end

		// Start the segment now selected; a silence keeps the timer values.
		if (load) begin
			seg  = seg_lookup(cur_d, 4'(pos_d));
			tl_d = seg.dur_ms;
			if (seg.tone) begin
				rl_d    = seg.reload;
				cp_d    = seg.compare;
				run_d   = 1'b1;
				restart = 1'b1;
			end else begin
				run_d = 1'b0;
			end
		end
	end

	// State registers, updated once per transaction taken from the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= PAT_NONE;
			pos_q <= '0;
			tl_q  <= 8'd0;
			run_q <= 1'b0;
			rl_q  <= 11'd0;
			cp_q  <= 10'd0;
		end else if (adv) begin
			cur_q <= cur_d;
			pos_q <= pos_d;
			tl_q  <= tl_d;
			run_q <= run_d;
			rl_q  <= rl_d;
			cp_q  <= cp_d;
		end
	end

	assign result.tone_on         = run_d;
	assign result.reload_value    = rl_d;
	assign result.compare_value   = cp_d;
	assign result.counter_restart = restart;
	assign result.active_pattern  = cur_d;

	// A counter restart only comes with a running tone.
	a_restart_runs: assert property (@(posedge clk) disable iff (!arst_n)
		restart |-> run_d)
		else $error("counter restart without a running tone");

	// A running tone always belongs to a playing pattern.
	a_run_has_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		run_q |-> cur_q != PAT_NONE)
		else $error("tone running while idle");

	// Codes without a pattern never remain as the playing pattern.
	a_no_bad_code: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q != 3'd6 && cur_q != 3'd7)
		else $error("invalid pattern held");

	// State moves only when a transaction is processed.
	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(cur_q) && $stable(pos_q) && $stable(tl_q))
		else $error("state changed without a transaction");

endmodule

/* hdl/priority_tone_pattern_sequencer.sv */
// Top level of the priority tone pattern sequencer: stream ports, input and result stages.
// Depends on ptps_pkg and ptps_seq.
`timescale 1ns / 1ps

// The block takes one transaction per clock cycle, a play request or a millisecond tick
// (s_tuser), while the output side takes results, and returns exactly one result
// transaction for each; each transaction is registered in the input stage and its result
// in the result register. The single-pass step between the input register and the result
// register does the ROM lookup, one compare and one subtract, so requests and ticks can
// arrive back to back. A stalled result holds in the result register while one more
// transaction waits in the input stage.
// Each result reports whether the PWM tone runs, the held reload (period - 1) and compare
// (period / 2) values, a restart pulse for each tone segment started, and the playing
// pattern (0 when idle). A request for a lower-priority pattern than the one playing is
// ignored; pattern codes above 5 stop playback.
module priority_tone_pattern_sequencer
	import ptps_pkg::*;
#(
	parameter int MAX_SEGMENTS = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // pattern_code[2:0], tick_ms[18:3], zeros
	input  logic                   s_tuser,  // kind[0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // tone_on[0], reload_value[11:1],
	                                         // compare_value[21:12], counter_restart[22],
	                                         // active_pattern[25:23], zeros
);

	localparam int PW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	logic         v_s1_q;
	ptps_item_t   item_s1;
	logic         v_s2_q;
	ptps_result_t res_s2;
	ptps_result_t result;
	logic         adv;

	// The input stage moves on when the result register is free or being emptied.
	assign adv      = v_s1_q && (!v_s2_q || m_tready);
	assign s_tready = !v_s1_q || adv;

	// Input stage: capture the transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			v_s1_q <= 1'b1;
		end else if (adv) begin
			v_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.kind         <= s_tuser;
			item_s1.pattern_code <= s_tdata[2:0];
			item_s1.tick_ms      <= s_tdata[18:3];
		end
	end

	ptps_seq #(
		.MAX_SEGMENTS(MAX_SEGMENTS),
		.PW          (PW)
	) u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.adv   (adv),
		.item  (item_s1),
		.result(result)
	);

	// Result stage: holds the result until the output side takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2_q <= 1'b0;
		end else if (adv) begin
			v_s2_q <= 1'b1;
		end else if (m_tready) begin
			v_s2_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= result;
		end
	end

	assign m_tvalid = v_s2_q;
	assign m_tdata  = {6'd0, res_s2.active_pattern, res_s2.counter_restart,
	                   res_s2.compare_value, res_s2.reload_value, res_s2.tone_on};

endmodule

/* test/ptps_checker.sv */
// Result checker for the priority tone pattern sequencer: follows both stream channels,
// predicts each result from its own copy of the sequencer state and compares field by field.
// Depends on ptps_pkg for pattern codes, transaction kinds and stream widths.
`timescale 1ns / 1ps

module tone_sequence_checker
	import ptps_pkg::*;
#(
	parameter int MAX_SEGMENTS = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tuser,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	output int                     errors,
	output int                     pending,
	output int                     applied_items
);

	// One pattern segment: tone frequency (zero for silence) and length.
	typedef struct packed {
		logic [15:0] hz;
		logic [7:0]  ms;
	} tone_seg_t;

	// Fields of one result transaction.
	typedef struct packed {
		logic        tone_on;
		logic [10:0] reload_value;
		logic [9:0]  compare_value;
		logic        counter_restart;
		logic [2:0]  active_pattern;
	} pwm_report_t;

	// Mirror of the sequencer state.
	logic [2:0]  cur_pat;
	logic [2:0]  seg_pos;
	logic [7:0]  ms_left;
	logic        tone_running;
	logic [10:0] reload_held;
	logic [9:0]  compare_held;

	pwm_report_t pwm_report_q[$];
	pwm_report_t predicted;
	pwm_report_t oldest;
	pwm_report_t seen;
	int          fail_count;
	int          applied_count;

	// Segment table of every pattern, by frequency and duration.
	function automatic tone_seg_t pattern_segment(input logic [2:0] pat, input logic [2:0] pos);
		tone_seg_t s;
		s = '{hz: 16'd0, ms: 8'd0};
		case (pat)
			PAT_KEYPRESS: begin
				if (pos == 3'd0) s = '{16'd2600, 8'd35};
			end
			PAT_STARTUP: begin
				case (pos)
					3'd0: s = '{16'd1800, 8'd70};
					3'd1: s = '{16'd0, 8'd40};
					3'd2: s = '{16'd2600, 8'd90};
					default: ;
				endcase
			end
			PAT_LOWBATT: begin
				case (pos)
					3'd0, 3'd2: s = '{16'd1500, 8'd120};
					3'd1: s = '{16'd0, 8'd100};
					default: ;
				endcase
			end
			PAT_LINKLOST: begin
				case (pos)
					3'd0, 3'd2: s = '{16'd900, 8'd180};
					3'd1: s = '{16'd0, 8'd120};
					default: ;
				endcase
			end
			PAT_RADIOERROR: begin
				case (pos)
					3'd0, 3'd2, 3'd4: s = '{16'd700, 8'd250};
					3'd1, 3'd3: s = '{16'd0, 8'd100};
					default: ;
				endcase
			end
			default: ;
		endcase
		return s;
	endfunction

	function automatic int pattern_length(input logic [2:0] pat);
		case (pat)
			PAT_KEYPRESS:                          return 1;
			PAT_STARTUP, PAT_LOWBATT, PAT_LINKLOST: return 3;
			PAT_RADIOERROR:                        return 5;
			default:                               return 0;
		endcase
	endfunction

	// Playback ends; the timer values stay as they were.
	task automatic stop_playback();
		tone_running = 1'b0;
		cur_pat = PAT_NONE;
		seg_pos = 3'd0;
		ms_left = 8'd0;
	endtask

	// Enters the segment at seg_pos; a tone segment reloads the timer values.
	task automatic enter_segment(output logic restart);
		tone_seg_t   seg;
		int unsigned period;
		restart = 1'b0;
		if (cur_pat >= PATTERN_COUNT || seg_pos >= MAX_SEGMENTS) begin
			stop_playback();
		end else begin
			seg = pattern_segment(cur_pat, seg_pos);
			ms_left = seg.ms;
			if (seg.hz == 16'd0) begin
				tone_running = 1'b0;
			end else begin
				period = 32'd1000000 / seg.hz;
				reload_held = 11'(period - 1);
				compare_held = 10'(period / 2);
				tone_running = 1'b1;
				restart = 1'b1;
			end
		end
	endtask

	// Applies one input transaction and returns the result it produces.
	task automatic step_sequencer(input logic kind, input logic [2:0] code,
			input logic [15:0] elapsed, output pwm_report_t r);
		logic restart;
		int   next_pos;
		restart = 1'b0;
		if (kind == KIND_PLAY) begin
			if (code != PAT_NONE && code >= cur_pat) begin
				cur_pat = code;
				seg_pos = 3'd0;
				if (code >= PATTERN_COUNT || pattern_length(code) == 0)
					stop_playback();
				else
					enter_segment(restart);
			end
		end else if (cur_pat != PAT_NONE) begin
			if (elapsed < {8'd0, ms_left}) begin
				ms_left = ms_left - elapsed[7:0];
			end else begin
				next_pos = int'(seg_pos) + 1;
				if (next_pos >= pattern_length(cur_pat) || next_pos >= MAX_SEGMENTS) begin
					stop_playback();
				end else begin
					seg_pos = 3'(next_pos);
					enter_segment(restart);
				end
			end
		end
		r.tone_on = tone_running;
		r.reload_value = reload_held;
		r.compare_value = compare_held;
		r.counter_restart = restart;
		r.active_pattern = cur_pat;
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		fail_count++;
	endtask

	// Predict on every accepted input transaction, compare on every accepted result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_playback();
			reload_held = 11'd0;
			compare_held = 10'd0;
			pwm_report_q.delete();
			fail_count = 0;
			applied_count = 0;
			errors <= 0;
			pending <= 0;
			applied_items <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				step_sequencer(s_tuser, s_tdata[2:0], s_tdata[18:3], predicted);
				pwm_report_q.push_back(predicted);
				applied_count++;
			end
			if (m_tvalid && m_tready) begin
				seen.tone_on = m_tdata[0];
				seen.reload_value = m_tdata[11:1];
				seen.compare_value = m_tdata[21:12];
				seen.counter_restart = m_tdata[22];
				seen.active_pattern = m_tdata[25:23];
				if (pwm_report_q.size() == 0) begin
					report_mismatch($sformatf("result %h arrived with nothing expected", m_tdata));
				end else begin
					oldest = pwm_report_q.pop_front();
					if (seen.tone_on !== oldest.tone_on)
						report_mismatch($sformatf("tone_on %0d, expected %0d",
							seen.tone_on, oldest.tone_on));
					if (seen.reload_value !== oldest.reload_value)
						report_mismatch($sformatf("reload_value %0d, expected %0d",
							seen.reload_value, oldest.reload_value));
					if (seen.compare_value !== oldest.compare_value)
						report_mismatch($sformatf("compare_value %0d, expected %0d",
							seen.compare_value, oldest.compare_value));
					if (seen.counter_restart !== oldest.counter_restart)
						report_mismatch($sformatf("counter_restart %0d, expected %0d",
							seen.counter_restart, oldest.counter_restart));
					if (seen.active_pattern !== oldest.active_pattern)
						report_mismatch($sformatf("active_pattern %0d, expected %0d",
							seen.active_pattern, oldest.active_pattern));
				end
			end
			errors <= fail_count;
			pending <= pwm_report_q.size();
			applied_items <= applied_count;
		end
	end

endmodule

/* test/testbench.sv */
// Top of the priority tone pattern sequencer testbench: clock, reset, stimulus and verdict.
// Depends on ptps_pkg, priority_tone_pattern_sequencer and tone_sequence_checker.
`timescale 1ns / 1ps

module testbench;
	import ptps_pkg::*;

	// Codes above the last pattern: they outrank everything and stop playback.
	localparam logic [2:0]  PAT_BEYOND_6 = 3'd6;
	localparam logic [2:0]  PAT_BEYOND_7 = 3'd7;
	localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;
	localparam int          CYCLE_LIMIT  = 400000;
	localparam int          TAIL_CYCLES  = 10;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = KIND_PLAY;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	int errors;
	int pending;
	int applied_items;
	int cycle_count = 0;
	int src_idle_pct = 20;
	int sink_idle_pct = 20;
	int stall_left = 0;

	priority_tone_pattern_sequencer u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	tone_sequence_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tuser       (s_tuser),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.errors        (errors),
		.pending       (pending),
		.applied_items (applied_items)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** priority_tone_pattern_sequencer: FAILED **");
			$finish;
		end
	end

	// Result side backpressure in random bursts.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
			stall_left <= $urandom_range(0, 12);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Offers one transaction, waits for it to be taken, then maybe idles for a burst.
	task automatic send_item(input logic kind, input logic [2:0] code, input logic [15:0] elapsed);
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {{(IN_TDATA_W - 19){1'b0}}, elapsed, code};
		do @(posedge clk); while (!s_tready);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
	endtask

	// Stops sending until every expected result has come back.
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Tick lengths: mostly short ones that walk through a segment, some that end it at once.
	function automatic logic [15:0] random_elapsed();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 50) return 16'($urandom_range(0, 40));
		if (pick < 75) return 16'($urandom_range(0, 255));
		if (pick < 85) return 16'($urandom_range(255, 65535));
		if (pick < 90) return 16'd0;
		return 16'($urandom);
	endfunction

	// A play request followed by ticks, with stray requests mixed in now and then.
	task automatic play_and_tick();
		int ticks;
		ticks = $urandom_range(2, 16);
		send_item(KIND_PLAY, 3'($urandom_range(1, 5)), 16'($urandom));
		repeat (ticks) begin
			if ($urandom_range(0, 9) == 0)
				send_item(KIND_PLAY, 3'($urandom_range(0, 7)), 16'($urandom));
			send_item(KIND_TICK, 3'($urandom_range(0, 7)), random_elapsed());
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: idle ticks, ignored and lower-priority requests, restarts, silences,
		// keypress, link-lost and radio-error run to their end, and the out-of-range codes.
		send_item(KIND_TICK, PAT_NONE, 16'd0);
		send_item(KIND_TICK, PAT_NONE, ELAPSED_MAX);
		send_item(KIND_PLAY, PAT_NONE, 16'd0);
		send_item(KIND_PLAY, PAT_KEYPRESS, 16'd0);
		send_item(KIND_TICK, PAT_NONE, 16'd10);
		send_item(KIND_TICK, PAT_NONE, 16'd0);
		send_item(KIND_TICK, PAT_NONE, 16'd25);
		send_item(KIND_PLAY, PAT_STARTUP, 16'd0);
		send_item(KIND_PLAY, PAT_KEYPRESS, 16'd0);
		send_item(KIND_PLAY, PAT_STARTUP, 16'd0);
		send_item(KIND_TICK, PAT_NONE, 16'd70);
		send_item(KIND_TICK, PAT_NONE, 16'd40);
		send_item(KIND_PLAY, PAT_LOWBATT, 16'd0);
		send_item(KIND_PLAY, PAT_LINKLOST, 16'd0);
		send_item(KIND_TICK, PAT_NONE, ELAPSED_MAX);
		send_item(KIND_TICK, PAT_NONE, 16'd200);
		send_item(KIND_TICK, PAT_NONE, 16'd180);
		send_item(KIND_PLAY, PAT_RADIOERROR, ELAPSED_MAX);
		repeat (5) send_item(KIND_TICK, PAT_RADIOERROR, ELAPSED_MAX);
		send_item(KIND_PLAY, PAT_LINKLOST, 16'd0);
		send_item(KIND_PLAY, PAT_BEYOND_6, 16'd0);
		send_item(KIND_PLAY, PAT_RADIOERROR, 16'd0);
		send_item(KIND_PLAY, PAT_BEYOND_7, ELAPSED_MAX);
		drain();

		// Random sequences with idling on both sides.
		src_idle_pct <= 30;
		sink_idle_pct <= 30;
		while (applied_items < 300) play_and_tick();
		drain();

		// Stretches with and without idling.
		while (applied_items < 500) begin
			src_idle_pct <= ($urandom_range(0, 1) != 0) ? 15 : 0;
			sink_idle_pct <= ($urandom_range(0, 1) != 0) ? 15 : 0;
			play_and_tick();
		end

		// Closing part at full rate.
		src_idle_pct <= 0;
		sink_idle_pct <= 0;
		while (applied_items < 630) play_and_tick();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0) begin
			$display("** priority_tone_pattern_sequencer: PASSED **");
		end else begin
			$display("** priority_tone_pattern_sequencer: FAILED **");
		end
		$finish;
	end

endmodule
